FILE: design/assert_macros.svh
// Assertion macros shared by the polygon check RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ccpc_pkg.sv
// Shared types and constants for the convex clockwise polygon check.
// No dependencies; used by ccpc_front, ccpc_back and the top level.
package ccpc_pkg;

  localparam int COORD_W = 20;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int SUM_W   = 48;
  localparam int IN_W    = 2 * COORD_W;
  localparam int OUT_W   = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] FLIP_TARGET = 2'd2;
  localparam logic [1:0] FLIP_SAT    = 2'd3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_LAST   = 2'd1,
    KIND_START  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } item_t;

endpackage

FILE: design/convex_clockwise_polygon_check_unit.sv
// Convex clockwise polygon check. A start item (tuser high) loads the closing vertex and
// clears the polygon state; each following vertex adds one edge, and the vertex flagged by
// tlast yields one result: bit 0 convex and clockwise, bit 1 convex, bit 2 clockwise.
// One item is taken per clock unless a result stalls on m_axis and the queue fills; a last
// vertex passes through the queue, the edge stage and the product stage, and then the
// accumulate step writes the result register. A four-entry queue lets up to four input
// items flow in while a result waits on m_axis.
// Depends on ccpc_pkg, ccpc_front, ccpc_back and assert_macros.svh.
`include "assert_macros.svh"

module convex_clockwise_polygon_check_unit #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ccpc_pkg::IN_W-1:0]     s_axis_tdata,   // vertex_x[19:0], vertex_y[39:20]
  input  logic                          s_axis_tuser,   // start_req
  input  logic                          s_axis_tlast,   // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ccpc_pkg::OUT_W-1:0]    m_axis_tdata    // accepted, is_convex, is_clockwise
);

  logic            q_valid, q_ready;
  ccpc_pkg::item_t q_item;

  ccpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .start_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .x_i        (s_axis_tdata[ccpc_pkg::COORD_W-1:0]),
    .y_i        (s_axis_tdata[ccpc_pkg::IN_W-1:ccpc_pkg::COORD_W]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  ccpc_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

  // back end must not drain the queue while its result is stuck
  `CCPC_ASSERT(a_no_pop_on_stall, (m_axis_tvalid && !m_axis_tready) |-> !(q_valid && q_ready), "queue popped while result stalled")
  // a full queue always offers an item
  `CCPC_ASSERT(a_full_has_item, !s_axis_tready |-> q_valid, "input blocked with empty queue")
  // full and not draining stays full
  `CCPC_ASSERT_NEXT(a_full_holds, !s_axis_tready && !(q_valid && q_ready), !s_axis_tready, "queue lost entries without a pop")
  `CCPC_ASSERT(a_result_consistent, m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[1] && m_axis_tdata[2])), "accepted flag disagrees")

endmodule

FILE: design/ccpc_front.sv
// Input side: classifies each vertex item and queues it for the back end.
// Depends on ccpc_pkg.
module ccpc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              start_i,
  input  logic                              last_i,
  input  logic signed [ccpc_pkg::COORD_W-1:0] x_i,
  input  logic signed [ccpc_pkg::COORD_W-1:0] y_i,
  output logic                              q_valid_o,
  input  logic                              q_ready_i,
  output ccpc_pkg::item_t                   q_item_o
);

  ccpc_pkg::item_t                   entries_q [ccpc_pkg::QUEUE_DEPTH];
  ccpc_pkg::item_t                   in_item;
  logic [ccpc_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ccpc_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ccpc_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push, pop;

  // start wins over last
  always_comb begin
    if (start_i) begin
      in_item.kind = ccpc_pkg::KIND_START;
    end else if (last_i) begin
      in_item.kind = ccpc_pkg::KIND_LAST;
    end else begin
      in_item.kind = ccpc_pkg::KIND_VERTEX;
    end
    in_item.x = x_i;
    in_item.y = y_i;
  end

  assign in_ready_o = (cnt_q != ccpc_pkg::QCNT_W'(ccpc_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = entries_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

FILE: design/ccpc_back.sv
// Back end: three-stage edge pipeline (edge, products, accumulate) and result register.
// Depends on ccpc_pkg.
module ccpc_back #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  ccpc_pkg::item_t               q_item_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [ccpc_pkg::OUT_W-1:0]    res_data_o
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  typedef struct packed {
    ccpc_pkg::sign_e now;
    ccpc_pkg::sign_e first;
    logic [1:0]      flips;
  } axis_t;

  function automatic ccpc_pkg::sign_e sign_of(logic neg, logic nz);
    ccpc_pkg::sign_e s;
    if (!nz) begin
      s = ccpc_pkg::SIGN_NONE;
    end else if (neg) begin
      s = ccpc_pkg::SIGN_NEG;
    end else begin
      s = ccpc_pkg::SIGN_POS;
    end
    return s;
  endfunction

  function automatic axis_t track(axis_t a, ccpc_pkg::sign_e s);
    axis_t r;
    r = a;
    if (s != ccpc_pkg::SIGN_NONE) begin
      if (a.now == ccpc_pkg::SIGN_NONE) begin
        r.first = s;
      end else if (a.now != s && a.flips != ccpc_pkg::FLIP_SAT) begin
        r.flips = a.flips + 2'd1;
      end
      r.now = s;
    end
    return r;
  endfunction

  // closing edge counts a flip if it differs from the opening one
  function automatic axis_t wrap(axis_t a);
    axis_t r;
    r = a;
    if (a.now != ccpc_pkg::SIGN_NONE && a.first != ccpc_pkg::SIGN_NONE &&
        a.now != a.first && a.flips != ccpc_pkg::FLIP_SAT) begin
      r.flips = a.flips + 2'd1;
    end
    return r;
  endfunction

  logic stall, pop, c_go;

  // stage A: edge against the current vertex
  logic signed [ccpc_pkg::COORD_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [ccpc_pkg::EDGE_W-1:0]  pdx_q, pdx_d, pdy_q, pdy_d;
  logic signed [ccpc_pkg::EDGE_W-1:0]  ax, ay, sy;
  logic                                a_vld_q;
  ccpc_pkg::kind_e                     a_kind_q;
  logic signed [ccpc_pkg::EDGE_W-1:0]  a_ax_q, a_ay_q, a_sy_q, a_pdx_q, a_pdy_q;

  // stage B: products
  logic                                b_vld_q;
  ccpc_pkg::kind_e                     b_kind_q;
  logic signed [ccpc_pkg::PROD_W-1:0]  b_psum_q, b_p1_q, b_p2_q;
  ccpc_pkg::sign_e                     b_sx_q, b_sy_q;

  // stage C: accumulated polygon state
  logic signed [ccpc_pkg::SUM_W-1:0]   sum_q, sum_d, sum_sat;
  logic signed [ccpc_pkg::SUM_W:0]     sum_ext;
  logic signed [ccpc_pkg::PROD_W:0]    xprod;
  ccpc_pkg::sign_e                     cross_s, cs_q, cs_d, cs_nxt;
  axis_t                               xa_q, xa_d, ya_q, ya_d;
  axis_t                               xa_fin, ya_fin;
  logic                                failed_q, failed_d, fail_nxt, cross_fail;
  logic [CNT_W-1:0]                    cnt_q, cnt_d, cnt_inc;
  logic                                convex, cw;

  logic                                out_vld_q, out_vld_d;
  logic [ccpc_pkg::OUT_W-1:0]          out_data_q, out_data_d;

  assign stall     = out_vld_q && !res_ready_i;
  assign q_ready_o = !stall;
  assign pop       = q_valid_i && !stall;
  assign c_go      = b_vld_q && !stall;

  assign ax = {q_item_i.x[ccpc_pkg::COORD_W-1], q_item_i.x} - {cur_x_q[ccpc_pkg::COORD_W-1], cur_x_q};
  assign ay = {q_item_i.y[ccpc_pkg::COORD_W-1], q_item_i.y} - {cur_y_q[ccpc_pkg::COORD_W-1], cur_y_q};
  assign sy = {q_item_i.y[ccpc_pkg::COORD_W-1], q_item_i.y} + {cur_y_q[ccpc_pkg::COORD_W-1], cur_y_q};

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    pdx_d   = pdx_q;
    pdy_d   = pdy_q;
    if (pop) begin
      cur_x_d = q_item_i.x;
      cur_y_d = q_item_i.y;
      if (q_item_i.kind == ccpc_pkg::KIND_START) begin
        pdx_d = '0;
        pdy_d = '0;
      end else begin
        pdx_d = ax;
        pdy_d = ay;
      end
    end
  end

  always_comb begin
    sum_ext = {sum_q[ccpc_pkg::SUM_W-1], sum_q}
            + {{(ccpc_pkg::SUM_W + 1 - ccpc_pkg::PROD_W){b_psum_q[ccpc_pkg::PROD_W-1]}}, b_psum_q};
    if (sum_ext[ccpc_pkg::SUM_W] != sum_ext[ccpc_pkg::SUM_W-1]) begin
      sum_sat = sum_ext[ccpc_pkg::SUM_W] ? ccpc_pkg::SUM_MIN : ccpc_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_ext[ccpc_pkg::SUM_W-1:0];
    end

    xprod      = {b_p1_q[ccpc_pkg::PROD_W-1], b_p1_q} - {b_p2_q[ccpc_pkg::PROD_W-1], b_p2_q};
    cross_s    = sign_of(xprod[ccpc_pkg::PROD_W], |xprod);
    cross_fail = (cs_q != ccpc_pkg::SIGN_NONE) && (cross_s != ccpc_pkg::SIGN_NONE) &&
                 (cross_s != cs_q);
    cs_nxt     = (cs_q == ccpc_pkg::SIGN_NONE) ? cross_s : cs_q;

    cnt_inc = (cnt_q <= CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

    xa_fin = track(xa_q, b_sx_q);
    ya_fin = track(ya_q, b_sy_q);
    if (b_kind_q == ccpc_pkg::KIND_LAST) begin
      xa_fin = wrap(xa_fin);
      ya_fin = wrap(ya_fin);
    end

    fail_nxt = failed_q || (cnt_inc > CNT_MAX) || cross_fail ||
               (xa_fin.flips > ccpc_pkg::FLIP_TARGET) || (ya_fin.flips > ccpc_pkg::FLIP_TARGET);
    convex   = !fail_nxt && (xa_fin.flips == ccpc_pkg::FLIP_TARGET) &&
               (ya_fin.flips == ccpc_pkg::FLIP_TARGET);
    cw       = sum_sat[ccpc_pkg::SUM_W-1];

    sum_d      = sum_q;
    cs_d       = cs_q;
    xa_d       = xa_q;
    ya_d       = ya_q;
    failed_d   = failed_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !res_ready_i;
    out_data_d = out_data_q;

    if (c_go) begin
      case (b_kind_q)
        ccpc_pkg::KIND_START: begin
          sum_d    = '0;
          cs_d     = ccpc_pkg::SIGN_NONE;
          xa_d     = '0;
          ya_d     = '0;
          failed_d = 1'b0;
          cnt_d    = '0;
        end
        default: begin
          sum_d    = sum_sat;
          cs_d     = cs_nxt;
          xa_d     = xa_fin;
          ya_d     = ya_fin;
          failed_d = fail_nxt;
          cnt_d    = cnt_inc;
          if (b_kind_q == ccpc_pkg::KIND_LAST) begin
            out_vld_d  = 1'b1;
            out_data_d = {{(ccpc_pkg::OUT_W - 3){1'b0}}, cw, convex, convex && cw};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      pdx_q     <= '0;
      pdy_q     <= '0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      sum_q     <= '0;
      cs_q      <= ccpc_pkg::SIGN_NONE;
      xa_q      <= '0;
      ya_q      <= '0;
      failed_q  <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      pdx_q     <= pdx_d;
      pdy_q     <= pdy_d;
      if (!stall) begin
        a_vld_q <= q_valid_i;
        b_vld_q <= a_vld_q;
      end
      sum_q     <= sum_d;
      cs_q      <= cs_d;
      xa_q      <= xa_d;
      ya_q      <= ya_d;
      failed_q  <= failed_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload stages, no reset needed
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      a_kind_q <= q_item_i.kind;
      a_ax_q   <= ax;
      a_ay_q   <= ay;
      a_sy_q   <= sy;
      a_pdx_q  <= pdx_q;
      a_pdy_q  <= pdy_q;
      b_kind_q <= a_kind_q;
      b_psum_q <= a_ax_q * a_sy_q;
      b_p1_q   <= a_pdx_q * a_ay_q;
      b_p2_q   <= a_ax_q * a_pdy_q;
      b_sx_q   <= sign_of(a_ax_q[ccpc_pkg::EDGE_W-1], |a_ax_q);
      b_sy_q   <= sign_of(a_ay_q[ccpc_pkg::EDGE_W-1], |a_ay_q);
    end
    out_data_q <= out_data_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_data_o  = out_data_q;

endmodule
